// ===== sv/rmvt_pkg.sv =====
`default_nettype none
package rmvt_pkg;

  localparam int ENTRIES  = 1024;
  localparam int ADDR_W   = $clog2(ENTRIES);
  localparam int IDX_W    = 10;
  localparam int SCNT_W   = 20;
  localparam int COUNT_W  = 20;
  localparam int DIV_W    = COUNT_W + 1;
  localparam int VAL_W    = 32;
  localparam int SPREAD_W = 63;
  localparam int CFG_W    = 2;

  localparam logic [SPREAD_W-1:0] SPREAD_MAX = {SPREAD_W{1'b1}};
  localparam logic [CFG_W-1:0]    CH_PAIR    = 2'd2;

  // divider retires two quotient bits per stage
  localparam int DIV_BITS  = 2;
  localparam int NDIV      = VAL_W / DIV_BITS;
  localparam int STG_DELTA = 1;
  localparam int STG_DIV0  = 2;
  localparam int STG_MEAN  = NDIV + 2;
  localparam int STG_DEV   = NDIV + 3;
  localparam int STG_PROD  = NDIV + 4;
  localparam int NSTG      = NDIV + 5;

  typedef struct packed {
    logic [VAL_W-1:0]    mean_a;
    logic [SPREAD_W-1:0] spread_a;
    logic [VAL_W-1:0]    mean_b;
    logic [SPREAD_W-1:0] spread_b;
  } entry_t;

  typedef struct packed {
    logic [VAL_W-1:0]    x;
    logic [VAL_W-1:0]    mean;
    logic [SPREAD_W-1:0] spread;
    logic                neg;
    logic [VAL_W-1:0]    mag;
    logic [VAL_W-1:0]    num;
    logic [DIV_W-1:0]    rem;
    logic [VAL_W-1:0]    quo;
    logic [VAL_W-1:0]    nmean;
    logic [VAL_W-1:0]    dev;
    logic [2*VAL_W-1:0]  prod;
  } lane_t;

  typedef struct packed {
    logic [ADDR_W-1:0] idx;
    logic [DIV_W-1:0]  div;
    logic              pair;
    lane_t             a;
    lane_t             b;
  } item_t;

  // delta = x - mean, split into sign and magnitude
  function automatic lane_t lane_delta(lane_t l);
    logic [VAL_W:0] dl;
    logic [VAL_W:0] m;
    dl = {l.x[VAL_W-1], l.x} - {l.mean[VAL_W-1], l.mean};
    m = dl[VAL_W] ? (~dl + 1'b1) : dl;
    l.neg = dl[VAL_W];
    l.mag = m[VAL_W-1:0];
    l.num = m[VAL_W-1:0];
    l.rem = '0;
    l.quo = '0;
    return l;
  endfunction

  // one restoring divide step
  function automatic lane_t lane_div_step(lane_t l, logic [DIV_W-1:0] d);
    logic [DIV_W:0] r;
    r = {l.rem, l.num[VAL_W-1]};
    l.num = {l.num[VAL_W-2:0], 1'b0};
    if (r >= {1'b0, d}) begin
      r = r - {1'b0, d};
      l.quo = {l.quo[VAL_W-2:0], 1'b1};
    end else begin
      l.quo = {l.quo[VAL_W-2:0], 1'b0};
    end
    l.rem = r[DIV_W-1:0];
    return l;
  endfunction

  // quotient truncates toward zero, so the sign is reapplied afterwards
  function automatic lane_t lane_mean(lane_t l);
    logic [VAL_W:0] st;
    logic [VAL_W:0] s;
    st = l.neg ? (~{1'b0, l.quo} + 1'b1) : {1'b0, l.quo};
    s = {l.mean[VAL_W-1], l.mean} + st;
    l.nmean = s[VAL_W-1:0];
    return l;
  endfunction

  function automatic lane_t lane_dev(lane_t l);
    logic [VAL_W:0] dv;
    logic [VAL_W:0] m;
    dv = {l.x[VAL_W-1], l.x} - {l.nmean[VAL_W-1], l.nmean};
    m = dv[VAL_W] ? (~dv + 1'b1) : dv;
    l.dev = m[VAL_W-1:0];
    return l;
  endfunction

  function automatic lane_t lane_prod(lane_t l);
    l.prod = l.mag * l.dev;
    return l;
  endfunction

endpackage
`default_nettype wire

// ===== sv/rmvt_ram.sv =====
`default_nettype none
module rmvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/running_mean_variance_table.sv =====
// A transaction accepted into stage 0 runs down the pipe, then the output register.
// Throughput: one transaction per cycle unless the output stalls; an item
// whose entry is in flight waits until that earlier update is written back.
// Reset: synchronous; after rst drops a clearing pass zeroes every table
// entry, and in_stall stays high for its length. channels_used resets to 2.
`default_nettype none
module running_mean_variance_table (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic        [rmvt_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic        [rmvt_pkg::IDX_W-1:0]    entry_index,
  input  wire logic        [rmvt_pkg::SCNT_W-1:0]   sample_count,
  input  wire logic signed [rmvt_pkg::VAL_W-1:0]    value_a,
  input  wire logic signed [rmvt_pkg::VAL_W-1:0]    value_b,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic             [rmvt_pkg::IDX_W-1:0]    result_index,
  output logic signed      [rmvt_pkg::VAL_W-1:0]    mean_a_out,
  output logic             [rmvt_pkg::SPREAD_W-1:0] spread_a_out,
  output logic signed      [rmvt_pkg::VAL_W-1:0]    mean_b_out,
  output logic             [rmvt_pkg::SPREAD_W-1:0] spread_b_out,
  output logic                                     overflow_flag
);

  localparam int LAST = rmvt_pkg::NSTG - 1;

  // configuration
  logic [rmvt_pkg::CFG_W-1:0] channels_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      channels_used <= rmvt_pkg::CH_PAIR;
    end else if (cfg_we) begin
      channels_used <= cfg_wdata;
    end
  end

  // clearing pass: top bit of the counter marks it done
  logic [rmvt_pkg::ADDR_W:0] clr_cnt;
  logic                      clearing;

  assign clearing = !clr_cnt[rmvt_pkg::ADDR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // pipeline registers; valid bits travel alongside
  rmvt_pkg::item_t pipe [rmvt_pkg::NSTG];
  logic            vld  [rmvt_pkg::NSTG];
  rmvt_pkg::item_t src0;
  rmvt_pkg::item_t in_item;
  rmvt_pkg::entry_t rd_entry;
  logic            adv;
  logic            acc;
  logic            hazard;
  logic [rmvt_pkg::ADDR_W-1:0] in_addr;

  // whole pipe moves together whenever the output register can take data
  assign adv     = !out_valid || !out_stall;
  assign in_addr = entry_index[rmvt_pkg::ADDR_W-1:0];

  // read-modify-write hazard: hold an item whose entry is still in flight
  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < rmvt_pkg::NSTG; k++) begin
      if (vld[k] && pipe[k].idx == in_addr) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_stall = clearing || !adv || hazard;
  assign acc      = in_valid && !in_stall;

  // incoming transaction; table fields are filled in from the registered read
  always_comb begin
    in_item      = '0;
    in_item.idx  = in_addr;
    in_item.div  = {1'b0, sample_count[rmvt_pkg::COUNT_W-1:0]} + 1'b1;
    in_item.pair = channels_used[1];
    in_item.a.x  = value_a;
    in_item.b.x  = value_b;
  end

  // stage 0: capture the transaction while the table read is in progress
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= acc;
    end
    if (acc) begin
      pipe[0] <= in_item;
    end
  end

  // merge the stored entry into the stage 0 item
  always_comb begin
    src0          = pipe[0];
    src0.a.mean   = rd_entry.mean_a;
    src0.a.spread = rd_entry.spread_a;
    src0.b.mean   = rd_entry.mean_b;
    src0.b.spread = rd_entry.spread_b;
  end

  function automatic rmvt_pkg::item_t stage_op(int k, rmvt_pkg::item_t it);
    rmvt_pkg::item_t o;
    o = it;
    if (k == rmvt_pkg::STG_DELTA) begin
      o.a = rmvt_pkg::lane_delta(it.a);
      o.b = rmvt_pkg::lane_delta(it.b);
    end else if (k >= rmvt_pkg::STG_DIV0 && k < rmvt_pkg::STG_MEAN) begin
      for (int s = 0; s < rmvt_pkg::DIV_BITS; s++) begin
        o.a = rmvt_pkg::lane_div_step(o.a, it.div);
        o.b = rmvt_pkg::lane_div_step(o.b, it.div);
      end
    end else if (k == rmvt_pkg::STG_MEAN) begin
      o.a = rmvt_pkg::lane_mean(it.a);
      o.b = rmvt_pkg::lane_mean(it.b);
    end else if (k == rmvt_pkg::STG_DEV) begin
      o.a = rmvt_pkg::lane_dev(it.a);
      o.b = rmvt_pkg::lane_dev(it.b);
    end else begin
      o.a = rmvt_pkg::lane_prod(it.a);
      o.b = rmvt_pkg::lane_prod(it.b);
    end
    return o;
  endfunction

  for (genvar k = 1; k < rmvt_pkg::NSTG; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= vld[k-1];
      end
      if (adv) begin
        pipe[k] <= stage_op(k, (k == 1) ? src0 : pipe[k-1]);
      end
    end
  end

  // final stage: saturating accumulate of the deviation product
  logic [rmvt_pkg::SPREAD_W+1:0] sum_a;
  logic [rmvt_pkg::SPREAD_W+1:0] sum_b;
  logic                          sat_a;
  logic                          sat_b;
  logic [rmvt_pkg::SPREAD_W-1:0] nspr_a;
  logic [rmvt_pkg::SPREAD_W-1:0] nspr_b;
  rmvt_pkg::entry_t              new_entry;
  logic                          ram_we;
  logic [rmvt_pkg::ADDR_W-1:0]   ram_waddr;
  rmvt_pkg::entry_t              ram_wdata;

  always_comb begin
    sum_a  = {2'b00, pipe[LAST].a.spread} + {1'b0, pipe[LAST].a.prod};
    sum_b  = {2'b00, pipe[LAST].b.spread} + {1'b0, pipe[LAST].b.prod};
    sat_a  = sum_a > {2'b00, rmvt_pkg::SPREAD_MAX};
    sat_b  = sum_b > {2'b00, rmvt_pkg::SPREAD_MAX};
    nspr_a = sat_a ? rmvt_pkg::SPREAD_MAX : sum_a[rmvt_pkg::SPREAD_W-1:0];
    nspr_b = sat_b ? rmvt_pkg::SPREAD_MAX : sum_b[rmvt_pkg::SPREAD_W-1:0];
    new_entry.mean_a   = pipe[LAST].a.nmean;
    new_entry.spread_a = nspr_a;
    // single channel leaves channel b as it was
    new_entry.mean_b   = pipe[LAST].pair ? pipe[LAST].b.nmean : pipe[LAST].b.mean;
    new_entry.spread_b = pipe[LAST].pair ? nspr_b : pipe[LAST].b.spread;
  end

  // write-back happens as the item enters the output register
  assign ram_we    = clearing || (adv && vld[LAST]);
  assign ram_waddr = clearing ? clr_cnt[rmvt_pkg::ADDR_W-1:0] : pipe[LAST].idx;
  assign ram_wdata = clearing ? '0 : new_entry;

  rmvt_ram #(
    .WIDTH ($bits(rmvt_pkg::entry_t)),
    .DEPTH (rmvt_pkg::ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (acc),
    .raddr (in_addr),
    .rdata (rd_entry)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[LAST];
    end
    if (adv && vld[LAST]) begin
      result_index  <= rmvt_pkg::IDX_W'(pipe[LAST].idx);
      mean_a_out    <= pipe[LAST].a.nmean;
      spread_a_out  <= nspr_a;
      mean_b_out    <= pipe[LAST].pair ? pipe[LAST].b.nmean : '0;
      spread_b_out  <= pipe[LAST].pair ? nspr_b : '0;
      overflow_flag <= sat_a || (pipe[LAST].pair && sat_b);
    end
  end

endmodule
`default_nettype wire

// ===== sv/rmvt_checker.sv =====
`default_nettype none
module rmvt_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                cfg_we,
  input wire logic        [rmvt_pkg::CFG_W-1:0]    cfg_wdata,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic        [rmvt_pkg::IDX_W-1:0]    result_index,
  input wire logic        [rmvt_pkg::SPREAD_W-1:0] spread_a_out,
  input wire logic signed [rmvt_pkg::VAL_W-1:0]    mean_b_out,
  input wire logic        [rmvt_pkg::SPREAD_W-1:0] spread_b_out,
  input wire logic                                overflow_flag
);

  logic [rmvt_pkg::CFG_W-1:0] chan_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_seen <= rmvt_pkg::CH_PAIR;
    end else if (cfg_we) begin
      chan_seen <= cfg_wdata;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_index) && $stable(spread_a_out))
    else $error("stalled output changed");

  a_clear_stall: assert property (@(posedge clk) $past(rst) |-> in_stall)
    else $error("input taken during table clear");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow_flag |->
      spread_a_out == rmvt_pkg::SPREAD_MAX || spread_b_out == rmvt_pkg::SPREAD_MAX)
    else $error("overflow without saturated sum");

  a_single_b_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !chan_seen[1] |-> mean_b_out == '0 && spread_b_out == '0)
    else $error("channel b reported in single-channel mode");

endmodule

bind running_mean_variance_table rmvt_checker u_rmvt_checker (.*);
`default_nettype wire

// ===== sim/running_mean_variance_table_test.sv =====
module running_mean_variance_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 21;
  localparam int STALL_LIMIT = 20000;
  localparam logic [63:0] SPREAD_TOP = 64'h7FFF_FFFF_FFFF_FFFF;

  // One input transaction.
  typedef struct {
    logic [rmvt_pkg::IDX_W-1:0]  idx;
    logic [rmvt_pkg::SCNT_W-1:0] cnt;
    logic [rmvt_pkg::VAL_W-1:0]  va;
    logic [rmvt_pkg::VAL_W-1:0]  vb;
  } sample_t;

  // One result transaction.
  typedef struct {
    logic [rmvt_pkg::IDX_W-1:0]    idx;
    logic [rmvt_pkg::VAL_W-1:0]    mean_a;
    logic [rmvt_pkg::SPREAD_W-1:0] spread_a;
    logic [rmvt_pkg::VAL_W-1:0]    mean_b;
    logic [rmvt_pkg::SPREAD_W-1:0] spread_b;
    logic                          ovf;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rmvt_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [rmvt_pkg::IDX_W-1:0] entry_index = '0;
  logic [rmvt_pkg::SCNT_W-1:0] sample_count = '0;
  logic signed [rmvt_pkg::VAL_W-1:0] value_a = '0;
  logic signed [rmvt_pkg::VAL_W-1:0] value_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [rmvt_pkg::IDX_W-1:0] result_index;
  logic signed [rmvt_pkg::VAL_W-1:0] mean_a_out;
  logic [rmvt_pkg::SPREAD_W-1:0] spread_a_out;
  logic signed [rmvt_pkg::VAL_W-1:0] mean_b_out;
  logic [rmvt_pkg::SPREAD_W-1:0] spread_b_out;
  logic overflow_flag;

  running_mean_variance_table u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .entry_index(entry_index), .sample_count(sample_count),
    .value_a(value_a), .value_b(value_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_index(result_index),
    .mean_a_out(mean_a_out), .spread_a_out(spread_a_out),
    .mean_b_out(mean_b_out), .spread_b_out(spread_b_out),
    .overflow_flag(overflow_flag)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Predictor copy of the table and of the channel register.
  logic signed [rmvt_pkg::VAL_W-1:0] mean_tab_a [rmvt_pkg::ENTRIES];
  logic [63:0]                       spread_tab_a [rmvt_pkg::ENTRIES];
  logic signed [rmvt_pkg::VAL_W-1:0] mean_tab_b [rmvt_pkg::ENTRIES];
  logic [63:0]                       spread_tab_b [rmvt_pkg::ENTRIES];
  logic [rmvt_pkg::CFG_W-1:0]        chan_mode;

  sample_t pending_samples[$];
  stats_t  expected_stats[$];

  int  errors = 0;
  int  accepted_in = 0;
  int  accepted_out = 0;
  int  sat_seen = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_receiver = 0;

  // One Welford step on a single channel; returns 1 on saturation.
  function automatic bit welford_step(inout logic signed [rmvt_pkg::VAL_W-1:0] mean,
                                      inout logic [63:0] spread,
                                      input logic signed [rmvt_pkg::VAL_W-1:0] x,
                                      input logic [rmvt_pkg::SCNT_W-1:0] cnt);
    longint delta, nmean, dev;
    logic [63:0] prod, mag_d, mag_v;
    delta = longint'(x) - longint'(mean);
    // SystemVerilog integer division truncates toward zero
    nmean = longint'(mean) + delta / (longint'(cnt) + 1);
    dev   = longint'(x) - nmean;
    mag_d = delta < 0 ? -delta : delta;
    mag_v = dev < 0 ? -dev : dev;
    prod  = mag_d * mag_v;
    mean  = nmean[rmvt_pkg::VAL_W-1:0];
    if (prod > SPREAD_TOP - spread) begin
      spread = SPREAD_TOP;
      return 1'b1;
    end
    spread = spread + prod;
    return 1'b0;
  endfunction

  function automatic stats_t fold_sample(sample_t s);
    stats_t r;
    int i;
    bit sat;
    i = s.idx % rmvt_pkg::ENTRIES;
    sat = welford_step(mean_tab_a[i], spread_tab_a[i], s.va, s.cnt);
    r.idx = rmvt_pkg::IDX_W'(i);
    r.mean_a = mean_tab_a[i];
    r.spread_a = spread_tab_a[i][rmvt_pkg::SPREAD_W-1:0];
    r.mean_b = '0;
    r.spread_b = '0;
    if (chan_mode >= rmvt_pkg::CH_PAIR) begin
      if (welford_step(mean_tab_b[i], spread_tab_b[i], s.vb, s.cnt)) sat = 1'b1;
      r.mean_b = mean_tab_b[i];
      r.spread_b = spread_tab_b[i][rmvt_pkg::SPREAD_W-1:0];
    end
    r.ovf = sat;
    return r;
  endfunction

  // Driver: at each edge, the current transaction either went through or is held.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_stats.insert(expected_stats.size(),
                              fold_sample(pending_samples.pop_front()));
        accepted_in++;
      end
      // a held transaction keeps its payload; a new one is loaded only once free
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid     <= 1'b1;
          entry_index  <= pending_samples[0].idx;
          sample_count <= pending_samples[0].cnt;
          value_a      <= pending_samples[0].va;
          value_b      <= pending_samples[0].vb;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall generation.
  always @(posedge clk) begin
    stats_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        accepted_out++;
        if (expected_stats.size() == 0) begin
          $error("unexpected result, index %0d", result_index);
          errors++;
        end else begin
          e = expected_stats.pop_front();
          if (e.ovf) sat_seen++;
          if (result_index !== e.idx) begin
            $error("result_index exp %0d got %0d", e.idx, result_index); errors++;
          end
          if (mean_a_out !== e.mean_a) begin
            $error("mean_a_out exp %h got %h", e.mean_a, mean_a_out); errors++;
          end
          if (spread_a_out !== e.spread_a) begin
            $error("spread_a_out exp %h got %h", e.spread_a, spread_a_out); errors++;
          end
          if (mean_b_out !== e.mean_b) begin
            $error("mean_b_out exp %h got %h", e.mean_b, mean_b_out); errors++;
          end
          if (spread_b_out !== e.spread_b) begin
            $error("spread_b_out exp %h got %h", e.spread_b, spread_b_out); errors++;
          end
          if (overflow_flag !== e.ovf) begin
            $error("overflow_flag exp %0d got %0d", e.ovf, overflow_flag); errors++;
          end
        end
      end
      out_stall <= hold_receiver || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: cycles with no transaction on either side.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Queue helpers.
  task automatic push_sample(input int idx, input int cnt, input int va, input int vb);
    sample_t s;
    s.idx = rmvt_pkg::IDX_W'(idx);
    s.cnt = rmvt_pkg::SCNT_W'(cnt);
    s.va = va;
    s.vb = vb;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid || expected_stats.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Register writes only happen with the pipeline empty.
  task automatic write_mode(input logic [rmvt_pkg::CFG_W-1:0] m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    chan_mode = m;
  endtask

  // Random round: sweep a set of entries several times with increasing counts,
  // so the statistics build up as a well-formed stream; some noise mixed in.
  task automatic random_rounds(input int total);
    int base, span, rounds, k, r, e;
    int center_a, center_b;
    while (total > 0) begin
      span = $urandom_range(4, 40);
      base = $urandom_range(0, 1023);
      rounds = $urandom_range(2, 8);
      center_a = $urandom;
      center_b = $urandom;
      for (r = 0; r < rounds && total > 0; r++) begin
        for (k = 0; k < span && total > 0; k++) begin
          e = (base + k) % rmvt_pkg::ENTRIES;
          case ($urandom_range(9))
            0: push_sample(e, $urandom, $urandom, $urandom);
            1: push_sample(e, r, center_a ^ $urandom, $urandom);
            default:
              push_sample(e, r, (center_a >>> $urandom_range(0, 20)) +
                          $signed($urandom_range(0, 65535)) - 32768,
                          (center_b >>> $urandom_range(0, 20)) +
                          $signed($urandom_range(0, 65535)) - 32768);
          endcase
          total--;
        end
      end
    end
  endtask

  initial begin
    int i, ph, cnt_hold;
    for (i = 0; i < rmvt_pkg::ENTRIES; i++) begin
      mean_tab_a[i] = '0; spread_tab_a[i] = '0;
      mean_tab_b[i] = '0; spread_tab_b[i] = '0;
    end
    chan_mode = rmvt_pkg::CH_PAIR;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: first sample, extreme values, count extremes, saturation.
    push_sample(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    push_sample(0, 1, 32'h8000_0000, 32'h7FFF_FFFF);
    push_sample(0, 1, 32'h7FFF_FFFF, 32'h8000_0000);
    push_sample(0, 1, 32'h8000_0000, 32'h7FFF_FFFF);
    for (i = 0; i < 6; i++) push_sample(0, 1, i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                                        i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    push_sample(1023, 20'hFFFFF, 32'hFFFF_FFFF, 32'h0001_0000);
    push_sample(1023, 20'hFFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_sample(512, 0, 32'h0001_8000, -32'sh0002_0000);
    push_sample(512, 3, 32'h0000_0000, 32'h0000_0001);
    push_sample(512, 1, 32'h0000_0000, 32'h0000_0000);
    // Inconsistent count on an untouched entry.
    push_sample(7, 500, 32'h1234_5678, 32'hEDCB_A988);
    wait_drained();

    // Single-channel modes, including the unused code 0; then code 3.
    write_mode(2'd1);
    push_sample(5, 0, 32'h0002_0000, 32'h7FFF_FFFF);
    push_sample(5, 1, 32'h0004_0000, 32'h8000_0000);
    push_sample(512, 2, 32'h7FFF_FFFF, 32'h1111_1111);
    wait_drained();
    write_mode(2'd0);
    push_sample(5, 2, 32'h8000_0000, 32'h2222_2222);
    push_sample(6, 0, 32'hFFFF_0000, 32'h3333_3333);
    wait_drained();
    write_mode(2'd3);
    push_sample(5, 3, 32'h0000_0001, 32'h4444_4444);
    push_sample(6, 1, 32'h7FFF_0000, 32'h8000_0001);
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both;
    // the channel mode changes between phases.
    for (ph = 0; ph < 4; ph++) begin
      write_mode(ph == 1 ? 2'd1 : (ph == 3 ? 2'd0 : rmvt_pkg::CH_PAIR));
      send_idle_pct  = (ph == 1) ? 64 : (ph == 3) ? 33 : 0;
      recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 33 : 0;
      random_rounds(280);
      wait_drained();
    end

    // Back-pressure: receiver holds off while the sender keeps offering,
    // so the pipeline fills and the input stalls.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_mode(rmvt_pkg::CH_PAIR);
    hold_receiver = 1;
    random_rounds(100);
    cnt_hold = 0;
    while (cnt_hold < 200) begin
      @(posedge clk);
      cnt_hold++;
    end
    hold_receiver = 0;
    wait_drained();

    $display("covered %0d inputs, %0d results, %0d saturating updates,",
             accepted_in, accepted_out, sat_seen);
    $display("channel codes 0..3, idle and stall mixes, and a long output hold");
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rmvt_pkg.sv
sv/rmvt_ram.sv
sv/running_mean_variance_table.sv
sv/rmvt_checker.sv
sim/running_mean_variance_table_test.sv
